// ===== rtl/cycloid_trot_gait_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Cycloid trot gait generator: assertion macros
// Shared property shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CYCLOID_TROT_GAIT_GENERATOR_MACROS_SVH
`define CYCLOID_TROT_GAIT_GENERATOR_MACROS_SVH

// Same-cycle implication
`define CGG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgg: same-cycle check failed");

// Next-cycle implication
`define CGG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgg: next-cycle check failed");

`endif

// ===== rtl/cgg_pkg.sv =====
// ----------------------------------------------------------------------------
// cgg_pkg
// Register map, datapath micro-operations and shared types of the gait
// generator.
// ----------------------------------------------------------------------------
package cgg_pkg;

	// Register map
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 16;
	localparam logic [REG_IDX_W-1:0] REG_GAIT_MODE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SWING_TICKS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_LEN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LIFT_LEN     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BASE_X       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BASE_Z       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TICK_STEP    = 3'd7;

	// Fixed-point constants (Q16)
	localparam int Q16_ONE           = 65536;
	localparam int INV_DOUBLE_PI_Q16 = 10430;
	localparam int POLY_C3           = 307;
	localparam int POLY_C2           = 5223;
	localparam int POLY_C1           = 42334;
	localparam int POLY_C0           = 102944;

	typedef struct packed {
		logic               gait_mode;
		logic [15:0]        period_ticks;
		logic [15:0]        swing_ticks;
		logic signed [15:0] stride_len;
		logic signed [15:0] lift_len;
		logic signed [15:0] base_x;
		logic signed [15:0] base_z;
		logic [7:0]         tick_step;
	} cfg_t;

	// Datapath micro-operations
	typedef logic [4:0] uop_t;
	localparam uop_t OP_NOP     = 5'd0;
	localparam uop_t OP_LOAD    = 5'd1;
	localparam uop_t OP_DIVP    = 5'd2;
	localparam uop_t OP_PF      = 5'd3;
	localparam uop_t OP_X       = 5'd5;
	localparam uop_t OP_MUL_XX  = 5'd6;
	localparam uop_t OP_X2      = 5'd7;
	localparam uop_t OP_MUL_X2S = 5'd8;
	localparam uop_t OP_S1      = 5'd9;
	localparam uop_t OP_S2      = 5'd10;
	localparam uop_t OP_S3      = 5'd11;
	localparam uop_t OP_MUL_XS  = 5'd12;
	localparam uop_t OP_SIN     = 5'd13;
	localparam uop_t OP_COS     = 5'd14;
	localparam uop_t OP_MUL_SK  = 5'd15;
	localparam uop_t OP_KX      = 5'd16;
	localparam uop_t OP_MUL_WKH = 5'd17;
	localparam uop_t OP_ACC     = 5'd18;
	localparam uop_t OP_MUL_WKL = 5'd19;
	localparam uop_t OP_WK      = 5'd20;
	localparam uop_t OP_MUL_HKZ = 5'd21;
	localparam uop_t OP_HK      = 5'd22;
	localparam uop_t OP_STORE   = 5'd23;
	localparam uop_t OP_PUBLISH = 5'd24;

	typedef logic [5:0] pc_t;
	localparam pc_t PROG_LAST = 6'd32;

	typedef struct packed {
		uop_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

	// Micro-program: divide for phase, then sine and cosine, then scaling
	function automatic uop_t prog_uop(input pc_t pc);
		uop_t op;
		unique case (pc)
			6'd0:  op = OP_DIVP;
			6'd1:  op = OP_PF;
			6'd2:  op = OP_X;
			6'd3:  op = OP_MUL_XX;
			6'd4:  op = OP_X2;
			6'd5:  op = OP_MUL_X2S;
			6'd6:  op = OP_S1;
			6'd7:  op = OP_MUL_X2S;
			6'd8:  op = OP_S2;
			6'd9:  op = OP_MUL_X2S;
			6'd10: op = OP_S3;
			6'd11: op = OP_MUL_XS;
			6'd12: op = OP_SIN;
			6'd13: op = OP_X;
			6'd14: op = OP_MUL_XX;
			6'd15: op = OP_X2;
			6'd16: op = OP_MUL_X2S;
			6'd17: op = OP_S1;
			6'd18: op = OP_MUL_X2S;
			6'd19: op = OP_S2;
			6'd20: op = OP_MUL_X2S;
			6'd21: op = OP_S3;
			6'd22: op = OP_MUL_XS;
			6'd23: op = OP_COS;
			6'd24: op = OP_MUL_SK;
			6'd25: op = OP_KX;
			6'd26: op = OP_MUL_WKH;
			6'd27: op = OP_ACC;
			6'd28: op = OP_MUL_WKL;
			6'd29: op = OP_WK;
			6'd30: op = OP_MUL_HKZ;
			6'd31: op = OP_HK;
			6'd32: op = OP_STORE;
			default: op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

// ===== rtl/cgg_regs.sv =====
// ----------------------------------------------------------------------------
// cgg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cgg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [cgg_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [cgg_pkg::REG_DATA_W-1:0] wr_data,
	output cgg_pkg::cfg_t                  cfg
);
	import cgg_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gait_mode    <= 1'b1;
			cfg_q.period_ticks <= 16'd1000;
			cfg_q.swing_ticks  <= 16'd500;
			cfg_q.stride_len   <= '0;
			cfg_q.lift_len     <= '0;
			cfg_q.base_x       <= '0;
			cfg_q.base_z       <= '0;
			cfg_q.tick_step    <= 8'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIT_MODE:    cfg_q.gait_mode    <= wr_data[0];
				REG_PERIOD_TICKS: cfg_q.period_ticks <= wr_data;
				REG_SWING_TICKS:  cfg_q.swing_ticks  <= wr_data;
				REG_STRIDE_LEN:   cfg_q.stride_len   <= $signed(wr_data);
				REG_LIFT_LEN:     cfg_q.lift_len     <= $signed(wr_data);
				REG_BASE_X:       cfg_q.base_x       <= $signed(wr_data);
				REG_BASE_Z:       cfg_q.base_z       <= $signed(wr_data);
				REG_TICK_STEP:    cfg_q.tick_step    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cgg_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgg_ctrl
// Sequencer: accepts a tick item, runs the datapath micro-program for an
// in-range tick and hands the result to the output register.
// ----------------------------------------------------------------------------
module cgg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output cgg_pkg::dp_cmd_t   cmd,
	input  cgg_pkg::dp_stat_t  stat
);
	import cgg_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;
	pc_t        pc_q, pc_d;
	uop_t       cur_op;

	assign cur_op = prog_uop(pc_q);

	// Next state and command
	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		cmd.op  = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				pc_d    = '0;
				state_d = stat.ok ? S_RUN : S_FIN;
			end
			S_RUN: begin
				cmd.op = cur_op;
				pc_d   = pc_q + 6'd1;
				if (pc_q == PROG_LAST)
					state_d = S_FIN;
				else if (cur_op == OP_DIVP)
					state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!stat.div_busy)
					state_d = S_RUN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/cgg_dp.sv =====
// ----------------------------------------------------------------------------
// cgg_dp
// Datapath: phase counter, bit-serial divider, shared multiplier with its
// post-processing, held coordinates and the output register.
// ----------------------------------------------------------------------------
module cgg_dp #(
	parameter int TIME_BITS        = 16,
	parameter int COORD_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cgg_pkg::cfg_t       cfg,
	input  logic                restart,
	input  cgg_pkg::dp_cmd_t    cmd,
	output cgg_pkg::dp_stat_t   stat,
	input  logic                out_stall,
	output logic                out_valid,
	output logic signed [15:0]  right_front_x,
	output logic signed [15:0]  right_front_z,
	output logic signed [15:0]  right_back_x,
	output logic signed [15:0]  right_back_z,
	output logic signed [15:0]  left_front_x,
	output logic signed [15:0]  left_front_z,
	output logic signed [15:0]  left_back_x,
	output logic signed [15:0]  left_back_z,
	output logic                cycle_running,
	output logic                in_range
);
	import cgg_pkg::*;

	localparam int PFW  = TIME_BITS + 16;
	localparam int ANGW = $clog2(SINE_TABLE_DEPTH);
	localparam int DIVW = PFW;
	localparam int DCW  = $clog2(DIVW + 1);
	localparam int KXW  = PFW + 2;
	localparam int KHW  = KXW - 16;
	localparam int MB   = (KHW > 18) ? KHW : 18;
	localparam int PRW  = 18 + MB;
	localparam int ACCW = PRW + 17;
	localparam int WKW  = ACCW - 16;
	localparam int CW   = WKW + 2;
	localparam int TCW  = (TIME_BITS > 16) ? TIME_BITS + 1 : 17;
	localparam int QTR  = SINE_TABLE_DEPTH / 4;

	localparam logic [ANGW+1:0] ANG_D1 = (ANGW+2)'(SINE_TABLE_DEPTH);
	localparam logic [ANGW+1:0] ANG_D2 = (ANGW+2)'(2 * SINE_TABLE_DEPTH);
	localparam logic [ANGW+1:0] ANG_D3 = (ANGW+2)'(3 * SINE_TABLE_DEPTH);
	localparam logic signed [CW-1:0] SAT_HI =
		CW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);
	localparam logic [63:0] PF_CLAMP = 64'd1 << 47;

	// Control state
	logic [TIME_BITS-1:0]         phase_q;
	logic                         ok_q, second_q, running_q;
	logic [DCW-1:0]               dcnt_q;
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] held_q [8];

	// Payload registers
	logic [TIME_BITS-1:0]    dt_q;
	logic [DIVW-1:0]         dvd_q;
	logic [15:0]             dvs_q;
	logic [15:0]             rem_q;
	logic [PFW-1:0]          pf_q;
	logic [ANGW-1:0]         cidx_q, r_q;
	logic [1:0]              quad_q;
	logic [16:0]             x_q, x2_q, s_q, kz_q;
	logic signed [17:0]      sin_q, hk_q;
	logic signed [PRW-1:0]   prod_q;
	logic signed [KXW-1:0]   kx_q;
	logic signed [ACCW-1:0]  acc_q;
	logic signed [WKW-1:0]   wk_q;
	logic signed [15:0]      out_q [8];
	logic                    out_run_q, out_rng_q;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] c;
		c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return COORD_BITS'(c);
	endfunction

	// Range check for the tick (after an optional restart)
	logic [15:0]          sw_c;
	logic [TIME_BITS-1:0] t_c;
	logic                 le_c, ok_c;
	logic [TCW-1:0]       dtw_c;

	assign sw_c  = (cfg.swing_ticks == 16'd0) ? 16'd1 : cfg.swing_ticks;
	assign t_c   = restart ? '0 : phase_q;
	assign le_c  = TCW'(t_c) <= TCW'(sw_c);
	assign ok_c  = le_c || (cfg.gait_mode && (TCW'(t_c) < TCW'(cfg.period_ticks)));
	assign dtw_c = le_c ? TCW'(t_c) : TCW'(t_c) - TCW'(sw_c);

	// Divider step: one quotient bit a cycle
	logic [16:0] rem_sh;
	logic        q_bit;
	assign rem_sh = {rem_q, dvd_q[DIVW-1]};
	assign q_bit  = rem_sh >= {1'b0, dvs_q};

	// Angle index, its quarter-turn shift and quadrant split
	logic [ANGW-1:0]  idx_c, ang_c, r_c;
	logic [ANGW:0]    csum_c;
	logic [ANGW+1:0]  q4_c;
	logic [1:0]       quad_c;

	assign idx_c  = ANGW'((32'(dvd_q[15:0]) * 32'(SINE_TABLE_DEPTH)) >> 16);
	assign csum_c = (ANGW+1)'(idx_c) + (ANGW+1)'(QTR);
	assign ang_c  = (cmd.op == OP_PF) ? idx_c : cidx_q;
	assign q4_c   = {ang_c, 2'b00};

	always_comb begin
		priority if (q4_c >= ANG_D3) begin
			quad_c = 2'd3;
			r_c    = ANGW'(q4_c - ANG_D3);
		end else if (q4_c >= ANG_D2) begin
			quad_c = 2'd2;
			r_c    = ANGW'(q4_c - ANG_D2);
		end else if (q4_c >= ANG_D1) begin
			quad_c = 2'd1;
			r_c    = ANGW'(q4_c - ANG_D1);
		end else begin
			quad_c = 2'd0;
			r_c    = ANGW'(q4_c);
		end
	end

	// Shared multiplier operand selection
	logic signed [17:0]    mul_a;
	logic signed [MB-1:0]  mul_b;
	logic signed [PRW-1:0] mul_c;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_XX: begin
				mul_a = $signed(18'(x_q));
				mul_b = $signed(MB'(x_q));
			end
			OP_MUL_X2S: begin
				mul_a = $signed(18'(x2_q));
				mul_b = $signed(MB'(s_q));
			end
			OP_MUL_XS: begin
				mul_a = $signed(18'(x_q));
				mul_b = $signed(MB'(s_q));
			end
			OP_MUL_SK: begin
				mul_a = sin_q;
				mul_b = $signed(MB'(INV_DOUBLE_PI_Q16));
			end
			OP_MUL_WKH: begin
				mul_a = 18'(cfg.stride_len);
				mul_b = MB'(kx_q >>> 16);
			end
			OP_MUL_WKL: begin
				mul_a = 18'(cfg.stride_len);
				mul_b = $signed(MB'(kx_q[15:0]));
			end
			OP_MUL_HKZ: begin
				mul_a = 18'(cfg.lift_len);
				mul_b = $signed(MB'(kz_q));
			end
			default: ;
		endcase
	end

	assign mul_c = mul_a * mul_b;

	// Post-processing of the registered product
	logic signed [PRW-1:0]  prod_sh;
	logic signed [PRW-1:0]  trig_mag;
	logic signed [17:0]     trig_c;
	logic signed [18:0]     kz_w;
	logic [63:0]            pf64, pcl;
	logic signed [PRW:0]    rsk_c;
	logic signed [ACCW-1:0] wsum_c;
	logic [16:0]            xq_c;

	assign prod_sh  = prod_q >>> 16;
	assign trig_mag = (prod_sh > PRW'(Q16_ONE)) ? PRW'(Q16_ONE) : prod_sh;
	assign trig_c   = (quad_q >= 2'd2) ? -18'(trig_mag) : 18'(trig_mag);
	assign kz_w     = (19'sd65536 - 19'(trig_c)) >>> 1;
	assign pf64     = 64'(pf_q);
	assign pcl      = (pf64 > PF_CLAMP) ? PF_CLAMP : pf64;
	assign rsk_c    = ((PRW+1)'(prod_q) + (PRW+1)'(32768)) >>> 16;
	assign wsum_c   = acc_q + ACCW'(prod_q);
	// Quarter-turn fraction: the table depth is a power of two, so shift
	assign xq_c     = 17'({r_q, 16'h0000} >> ANGW);

	// Coordinates for the store step
	logic signed [CW-1:0] bx_c, bz_c, w_c, wk_c, hk_c;
	logic signed [CW-1:0] sx_c, sz_c, px_c, pz_c;
	logic signed [COORD_BITS-1:0] sxs, szs, pxs, pzs, bxs, bzs;
	logic [TIME_BITS-1:0] nt_c;
	logic                 wrap_c;

	assign bx_c = CW'(cfg.base_x);
	assign bz_c = CW'(cfg.base_z);
	assign w_c  = CW'(cfg.stride_len);
	assign wk_c = CW'(wk_q);
	assign hk_c = CW'(hk_q);
	assign sx_c = second_q ? bx_c - (w_c - wk_c) : bx_c - wk_c;
	assign sz_c = second_q ? bz_c : bz_c - hk_c;
	assign px_c = second_q ? bx_c - wk_c : bx_c - (w_c - wk_c);
	assign pz_c = second_q ? bz_c - hk_c : bz_c;
	assign sxs  = sat(sx_c);
	assign szs  = sat(sz_c);
	assign pxs  = sat(px_c);
	assign pzs  = sat(pz_c);
	assign bxs  = sat(bx_c);
	assign bzs  = sat(bz_c);
	assign nt_c = phase_q + TIME_BITS'(cfg.tick_step);
	assign wrap_c = TCW'(nt_c) >= (cfg.gait_mode ? TCW'(cfg.period_ticks) : TCW'(sw_c));

	// Control state: counter, flags, divider count, held coordinates, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			ok_q        <= 1'b0;
			second_q    <= 1'b0;
			running_q   <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				held_q[i] <= '0;
		end else begin
			if (dcnt_q != '0)
				dcnt_q <= dcnt_q - DCW'(1);
			unique case (cmd.op)
				OP_LOAD: begin
					phase_q   <= t_c;
					ok_q      <= ok_c;
					second_q  <= !le_c;
					running_q <= 1'b0;
				end
				OP_DIVP: dcnt_q <= DCW'(DIVW);
				OP_STORE: begin
					phase_q   <= wrap_c ? '0 : nt_c;
					running_q <= !wrap_c;
					if (cfg.gait_mode) begin
						held_q[0] <= sxs; held_q[1] <= szs;
						held_q[2] <= pxs; held_q[3] <= pzs;
						held_q[4] <= pxs; held_q[5] <= pzs;
						held_q[6] <= sxs; held_q[7] <= szs;
					end else begin
						held_q[0] <= bxs; held_q[1] <= bzs;
						held_q[2] <= sxs; held_q[3] <= szs;
						held_q[4] <= sxs; held_q[5] <= szs;
						held_q[6] <= bxs; held_q[7] <= bzs;
					end
				end
				default: ;
			endcase
			// Drop the result once taken, load a new one when published
			if (cmd.op == OP_PUBLISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload: divider, trig and scaling registers, output register
	always_ff @(posedge clk) begin
		if (dcnt_q != '0) begin
			rem_q <= q_bit ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
			dvd_q <= {dvd_q[DIVW-2:0], q_bit};
		end
		unique case (cmd.op)
			OP_LOAD: dt_q <= TIME_BITS'(dtw_c);
			OP_DIVP: begin
				dvd_q <= DIVW'({dt_q, 16'h0000});
				dvs_q <= sw_c;
				rem_q <= '0;
			end
			OP_PF: begin
				pf_q   <= dvd_q[PFW-1:0];
				cidx_q <= (csum_c >= (ANGW+1)'(SINE_TABLE_DEPTH)) ?
					ANGW'(csum_c - (ANGW+1)'(SINE_TABLE_DEPTH)) : ANGW'(csum_c);
				quad_q <= quad_c;
				r_q    <= r_c;
			end
			OP_X: x_q <= quad_q[0] ? 17'(Q16_ONE) - xq_c : xq_c;
			OP_MUL_XX, OP_MUL_X2S, OP_MUL_XS, OP_MUL_SK,
			OP_MUL_WKH, OP_MUL_WKL, OP_MUL_HKZ: prod_q <= mul_c;
			OP_X2: begin
				x2_q <= 17'(prod_sh);
				s_q  <= 17'(POLY_C3);
			end
			OP_S1: s_q <= 17'(POLY_C2) - 17'(prod_sh);
			OP_S2: s_q <= 17'(POLY_C1) - 17'(prod_sh);
			OP_S3: s_q <= 17'(POLY_C0) - 17'(prod_sh);
			OP_SIN: begin
				sin_q  <= trig_c;
				quad_q <= quad_c;
				r_q    <= r_c;
			end
			OP_COS: kz_q <= 17'(kz_w);
			OP_KX:  kx_q <= $signed(KXW'(pcl)) - KXW'(rsk_c);
			OP_ACC: acc_q <= ACCW'(prod_q) <<< 16;
			OP_WK:  wk_q <= WKW'((wsum_c + ACCW'(32768)) >>> 16);
			OP_HK:  hk_q <= 18'(rsk_c);
			OP_PUBLISH: begin
				for (int i = 0; i < 8; i++)
					out_q[i] <= 16'(held_q[i]);
				out_run_q <= running_q;
				out_rng_q <= ok_q;
			end
			default: ;
		endcase
	end

	assign stat.ok       = ok_q;
	assign stat.div_busy = (dcnt_q != '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign right_front_x = out_q[0];
	assign right_front_z = out_q[1];
	assign right_back_x  = out_q[2];
	assign right_back_z  = out_q[3];
	assign left_front_x  = out_q[4];
	assign left_front_z  = out_q[5];
	assign left_back_x   = out_q[6];
	assign left_back_z   = out_q[7];
	assign cycle_running = out_run_q;
	assign in_range      = out_rng_q;

endmodule

// ===== rtl/cycloid_trot_gait_generator.sv =====
// ----------------------------------------------------------------------------
// cycloid_trot_gait_generator
// Four-leg cycloid foot trajectory generator for start and trot gaits.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the input channel (in_valid / in_stall, field restart) is one
//   control tick. It yields exactly one result item on the output channel
//   (out_valid / out_stall): eight Q8.8 foot coordinates plus cycle_running
//   and in_range.
//   Registers are written through wr_en / wr_index / wr_data while idle.
//   Keeping to that is up to the user; the block itself does not enforce it.
//   One item is in work at a time. The phase fraction comes from a bit-serial
//   divider with a DIVW-bit dividend, DIVW being TIME_BITS + 16, and every
//   product of the shared multiplier is registered before it is post-processed.
//   An out-of-range tick skips the micro-program and goes straight to its
//   result. The next tick is taken in the cycle after a result is published,
//   so a new tick is accepted only once the last one has been handed on.
//   The output register holds a finished result while the receiver stalls;
//   the next tick is accepted and computed meanwhile and waits to publish.
//   Reset restores the register defaults, clears the phase counter and the
//   held coordinates, and leaves the output channel empty.
// ----------------------------------------------------------------------------
`include "cycloid_trot_gait_generator_macros.svh"

module cycloid_trot_gait_generator #(
	parameter int TIME_BITS        = 16,
	parameter int COORD_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [cgg_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [cgg_pkg::REG_DATA_W-1:0] wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             right_front_x,
	output logic signed [15:0]             right_front_z,
	output logic signed [15:0]             right_back_x,
	output logic signed [15:0]             right_back_z,
	output logic signed [15:0]             left_front_x,
	output logic signed [15:0]             left_front_z,
	output logic signed [15:0]             left_back_x,
	output logic signed [15:0]             left_back_z,
	output logic                           cycle_running,
	output logic                           in_range
);
	import cgg_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	cgg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cgg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	cgg_dp #(
		.TIME_BITS        (TIME_BITS),
		.COORD_BITS       (COORD_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.restart       (restart),
		.cmd           (cmd),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.right_front_x (right_front_x),
		.right_front_z (right_front_z),
		.right_back_x  (right_back_x),
		.right_back_z  (right_back_z),
		.left_front_x  (left_front_x),
		.left_front_z  (left_front_z),
		.left_back_x   (left_back_x),
		.left_back_z   (left_back_z),
		.cycle_running (cycle_running),
		.in_range      (in_range)
	);

	// An accepted tick keeps the input side closed for the next cycle
	`CGG_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall)
	// A held (out-of-range) result never reports a running cycle
	`CGG_ASSERT_IMP(a_held_not_running, out_valid && !in_range, !cycle_running)
	// The divider is quiet whenever the block is open for a tick
	`CGG_ASSERT_IMP(a_idle_div_quiet, !in_stall, !stat.div_busy)
	// A publish always presents a result on the next cycle
	`CGG_ASSERT_NXT(a_publish_shows, cmd.op == OP_PUBLISH, out_valid)

endmodule

// ===== test/cycloid_trot_gait_generator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cycloid trot gait generator testbench
// Drives control ticks and register settings into the generator and predicts
// every foot target, the running flag and the in-range flag. Each result is
// compared field by field with the oldest prediction. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module cycloid_trot_gait_generator_test;
	import cgg_pkg::*;

	typedef struct {
		logic signed [15:0] coord [8];
		logic               running;
		logic               ok;
	} gait_pose_t;

	localparam string COORD_NAME [8] = '{"right_front_x", "right_front_z",
		"right_back_x", "right_back_z", "left_front_x", "left_front_z",
		"left_back_x", "left_back_z"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] right_front_x, right_front_z, right_back_x, right_back_z;
	logic signed [15:0] left_front_x, left_front_z, left_back_x, left_back_z;
	logic cycle_running, in_range;

	// Predictor state and register copy
	logic        m_mode;
	logic [15:0] m_period, m_swing;
	logic signed [15:0] m_width, m_height, m_base_x, m_base_z;
	logic [7:0]  m_step;
	logic [15:0] m_phase;
	longint      m_held [8];

	gait_pose_t pose_q [$];
	bit quiet = 1'b0;
	int errors = 0;
	int ticks_sent = 0;
	int n_in_range = 0, n_held = 0, n_wraps = 0;

	cycloid_trot_gait_generator u_dut (.*);

	always #10 clk = ~clk;

	// Receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet && ($urandom % 100 < 33);
	end

	function automatic longint rnd_q16(longint v);
		if (v >= 0)
			return (v + 32768) >>> 16;
		return -((-v + 32767) >>> 16);
	endfunction

	function automatic longint sat_coord(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	// Quarter-turn polynomial sine in Q16
	function automatic longint sine_q16(longint idx);
		longint quad, r, x, x2, s;
		quad = (idx * 4) / 256;
		r = idx * 4 - quad * 256;
		x = (r << 16) / 256;
		if (quad % 2 == 1)
			x = 65536 - x;
		x2 = (x * x) >>> 16;
		s = 307;
		s = 5223 - ((x2 * s) >>> 16);
		s = 42334 - ((x2 * s) >>> 16);
		s = 102944 - ((x2 * s) >>> 16);
		s = (x * s) >>> 16;
		if (s > 65536)
			s = 65536;
		return quad >= 2 ? -s : s;
	endfunction

	// Advance the gait by one tick when it is in range and return the pose it yields
	function automatic gait_pose_t step_gait(bit rs);
		gait_pose_t p;
		longint sw, t, dt, pf, idx, kx, kz, wk, hk, bx, bz, w, lim;
		longint sx, sz, px, pz;
		bit second;
		sw = m_swing == 0 ? 1 : m_swing;
		if (rs)
			m_phase = '0;
		t = m_phase;
		bx = m_base_x;
		bz = m_base_z;
		w = m_width;
		p.ok = 1'b1;
		p.running = 1'b0;
		second = 1'b0;
		if (t > sw) begin
			if (m_mode && t < m_period)
				second = 1'b1;
			else
				p.ok = 1'b0;
		end
		if (p.ok) begin
			dt = second ? t - sw : t;
			pf = (dt << 16) / sw;
			idx = ((pf & 'hFFFF) * 256) >>> 16;
			kx = pf - rnd_q16(sine_q16(idx) * INV_DOUBLE_PI_Q16);
			kz = (65536 - sine_q16((idx + 64) % 256)) >>> 1;
			wk = rnd_q16(w * kx);
			hk = rnd_q16(longint'(m_height) * kz);
			if (!second) begin
				sx = bx - wk; sz = bz - hk; px = bx - (w - wk); pz = bz;
			end else begin
				sx = bx - (w - wk); sz = bz; px = bx - wk; pz = bz - hk;
			end
			sx = sat_coord(sx); sz = sat_coord(sz);
			px = sat_coord(px); pz = sat_coord(pz);
			if (!m_mode)
				m_held = '{bx, bz, sx, sz, sx, sz, bx, bz};
			else
				m_held = '{sx, sz, px, pz, px, pz, sx, sz};
			t = (t + m_step) & 'hFFFF;
			lim = m_mode ? longint'(m_period) : sw;
			if (t >= lim)
				t = 0;
			else
				p.running = 1'b1;
			m_phase = t[15:0];
		end
		foreach (p.coord[i])
			p.coord[i] = m_held[i][15:0];
		return p;
	endfunction

	// Result checker: sample on the falling edge, taken at the next rising one
	always @(negedge clk) begin
		gait_pose_t e;
		logic signed [15:0] got [8];
		if (arst_n && out_valid && !out_stall) begin
			got = '{right_front_x, right_front_z, right_back_x, right_back_z,
				left_front_x, left_front_z, left_back_x, left_back_z};
			if (pose_q.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = pose_q.pop_front();
				foreach (got[i])
					if (got[i] !== e.coord[i]) begin
						$error("%s: expected %0d, got %0d", COORD_NAME[i], e.coord[i],
							got[i]);
						errors++;
					end
				if (cycle_running !== e.running) begin
					$error("cycle_running: expected %0d, got %0d", e.running,
						cycle_running);
					errors++;
				end
				if (in_range !== e.ok) begin
					$error("in_range: expected %0d, got %0d", e.ok, in_range);
					errors++;
				end
			end
		end
	end

	// Send one tick, sometimes with a random gap before it unless quiet
	task automatic send_tick(bit rs);
		bit free;
		gait_pose_t p;
		wr_en <= 1'b0;
		if (!quiet && $urandom % 100 < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		forever begin
			@(negedge clk);
			free = !in_stall;
			@(posedge clk);
			if (free)
				break;
		end
		p = step_gait(rs);
		if (!p.ok)
			n_held++;
		else begin
			n_in_range++;
			if (!p.running)
				n_wraps++;
		end
		pose_q.push_back(p);
		ticks_sent++;
	endtask

	// Hold the inputs and wait until every result is out
	task automatic drain();
		in_valid <= 1'b0;
		wr_en <= 1'b0;
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_GAIT_MODE:    m_mode = val[0];
			REG_PERIOD_TICKS: m_period = val;
			REG_SWING_TICKS:  m_swing = val;
			REG_STRIDE_LEN:   m_width = val;
			REG_LIFT_LEN:     m_height = val;
			REG_BASE_X:       m_base_x = val;
			REG_BASE_Z:       m_base_z = val;
			REG_TICK_STEP:    m_step = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_gait(bit mode, int period, int swing, int step);
		write_reg(REG_GAIT_MODE, 16'(mode));
		write_reg(REG_PERIOD_TICKS, 16'(period));
		write_reg(REG_SWING_TICKS, 16'(swing));
		write_reg(REG_TICK_STEP, 16'(step));
	endtask

	task automatic set_shape(int width, int height, int bx, int bz);
		write_reg(REG_STRIDE_LEN, 16'(width));
		write_reg(REG_LIFT_LEN, 16'(height));
		write_reg(REG_BASE_X, 16'(bx));
		write_reg(REG_BASE_Z, 16'(bz));
	endtask

	// Defaults after reset: zero stride, trot, counter counting up
	task automatic test_reset_defaults();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain();
	endtask

	// Extremes of the shape, both gaits, zero swing, period and step
	task automatic test_directed();
		set_gait(1'b0, 20, 4, 1);
		set_shape(32767, 32767, 32767, -32768);
		repeat (5) send_tick(1'b0);
		drain();
		set_gait(1'b1, 8, 3, 1);
		set_shape(-32768, -32768, -32768, 32767);
		send_tick(1'b1);
		repeat (8) send_tick(1'b0);
		drain();
		set_gait(1'b0, 0, 0, 1);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();
		set_gait(1'b1, 0, 2, 0);
		send_tick(1'b0);
		drain();
		// Counter stuck past the range: held output until a restart
		set_gait(1'b1, 10, 2, 3);
		set_shape(1234, -777, 300, -300);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();
		write_reg(REG_PERIOD_TICKS, 16'd5);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain();
	endtask

	// Counter wrap at the end of the largest period with the largest step
	task automatic test_counter_wrap();
		set_gait(1'b1, 65535, 65535, 255);
		set_shape(5000, 3000, 0, 0);
		quiet = 1'b1;
		send_tick(1'b1);
		repeat (258) send_tick(1'b0);
		drain();
		quiet = 1'b0;
	endtask

	// Random gaits in bursts, mostly small swing and period
	task automatic test_random_gaits();
		int batch;
		batch = 0;
		while (ticks_sent < 1650) begin
			drain();
			quiet = (batch % 9 == 4);
			if ($urandom % 10 == 0)
				set_gait($urandom % 2, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 255));
			else
				set_gait($urandom % 2, $urandom_range(0, 40), $urandom_range(0, 20),
					$urandom % 8 == 0 ? 0 : $urandom_range(1, 7));
			set_shape($urandom, $urandom, $urandom, $urandom);
			repeat ($urandom_range(20, 40))
				send_tick($urandom % 100 < 12);
			batch++;
		end
		drain();
		quiet = 1'b0;
	endtask

	initial begin
		m_mode = 1'b1; m_period = 1000; m_swing = 500; m_width = 0; m_height = 0;
		m_base_x = 0; m_base_z = 0; m_step = 1; m_phase = 0;
		m_held = '{0, 0, 0, 0, 0, 0, 0, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_counter_wrap();
		test_random_gaits();
		repeat (20) @(posedge clk);
		$display("Covered %0d ticks: %0d computed (%0d cycle ends), %0d held out of range.",
			ticks_sent, n_in_range, n_wraps, n_held);
		if (errors == 0 && pose_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cgg_pkg.sv
rtl/cgg_regs.sv
rtl/cgg_ctrl.sv
rtl/cgg_dp.sv
rtl/cycloid_trot_gait_generator.sv
test/cycloid_trot_gait_generator_test.sv
